### rtl/core/deque_with_delete_by_handle_assert.svh
// ----------------------------------------------------------------------------
// Deque assertion macros
// Shared forms for the concurrent assertions of the handle deque.
// ----------------------------------------------------------------------------
`ifndef DEQUE_WITH_DELETE_BY_HANDLE_ASSERT_SVH
`define DEQUE_WITH_DELETE_BY_HANDLE_ASSERT_SVH

// Condition on the same edge.
`define DQDEL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Condition on the following edge.
`define DQDEL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/dqdel_pkg.sv
// ----------------------------------------------------------------------------
// Deque package
// Types, command and status codes shared by the handle deque modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dqdel_pkg;

  localparam int HANDLE_W = 32;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 5;
  localparam int OP_W     = 3;

  localparam logic [CMD_W-1:0] CMD_PUSH_TAIL = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_HEAD = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP_HEAD  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_DELETE    = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  localparam logic [OP_W-1:0] OP_NONE      = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_TAIL = 3'd1;
  localparam logic [OP_W-1:0] OP_PUSH_HEAD = 3'd2;
  localparam logic [OP_W-1:0] OP_POP       = 3'd3;
  localparam logic [OP_W-1:0] OP_DELETE    = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [HANDLE_W-1:0] item_handle;
  } cmd_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] out_handle;
    logic [STATUS_W-1:0] status;
    logic [LEN_W-1:0]    length;
  } rsp_t;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [HANDLE_W-1:0] handle;
  } ctl_t;

endpackage

`default_nettype wire

### rtl/core/dqdel_cell.sv
// ----------------------------------------------------------------------------
// Deque cell
// One slot of the queue: holds a handle and an occupied flag, and takes its
// neighbour's contents when the queue shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module dqdel_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  dqdel_pkg::ctl_t               ctl,
  input  logic [dqdel_pkg::HANDLE_W-1:0] left_data,
  input  logic                          left_occ,
  input  logic [dqdel_pkg::HANDLE_W-1:0] right_data,
  input  logic                          right_occ,
  input  logic                          found_in,
  input  logic [dqdel_pkg::HANDLE_W-1:0] handle_in,
  output logic [dqdel_pkg::HANDLE_W-1:0] data,
  output logic                          occ,
  output logic                          found_out,
  output logic [dqdel_pkg::HANDLE_W-1:0] handle_out
);
  import dqdel_pkg::*;

  logic match;

  assign match      = occ && (data == ctl.handle);
  assign found_out  = found_in | match;
  assign handle_out = found_in ? handle_in : data;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else begin
      case (ctl.op)
        OP_PUSH_TAIL: begin
          if (!occ && left_occ) begin
            occ <= 1'b1;
          end
        end
        OP_PUSH_HEAD: occ <= left_occ;
        OP_POP:       occ <= right_occ;
        OP_DELETE: begin
          if (found_out) begin
            occ <= right_occ;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_PUSH_TAIL: begin
        if (!occ && left_occ) begin
          data <= ctl.handle;
        end
      end
      OP_PUSH_HEAD: data <= left_data;
      OP_POP:       data <= right_data;
      OP_DELETE: begin
        if (found_out) begin
          data <= right_data;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/deque_with_delete_by_handle.sv
// ----------------------------------------------------------------------------
// Handle deque with delete
// Bounded double-ended queue of 32-bit handles with delete by value.
// ----------------------------------------------------------------------------
// Commands arrive on the cmd channel (valid/ready) as a command code and a
// handle: insert at the tail, insert at the head, remove the head, or delete
// the first entry equal to the handle. Each transaction yields exactly one
// response on the rsp channel carrying the removed handle, a status and the
// new length.
// The queue is a row of DEPTH cells; every cell compares its handle and moves
// its contents to a neighbour in the same cycle. The response is registered,
// appearing in the cycle after the command transaction. One command per
// cycle is taken while the response register is empty or being drained. The
// first-match search ripples along the row of cells, which sets the clock
// period for large DEPTH.
// When the receiver stalls, the response is held and cmd_ready drops until
// it is taken. Reset empties the queue and clears any pending response; slot
// contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module deque_with_delete_by_handle #(
  parameter int DEPTH = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  dqdel_pkg::cmd_t cmd_data,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output dqdel_pkg::rsp_t rsp_data
);
  import dqdel_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic                accept;
  logic                full;
  logic                empty;
  logic                found;
  ctl_t                ctl;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  rsp_t                rsp_next;

  logic [HANDLE_W-1:0] data_w [DEPTH];
  logic [DEPTH-1:0]    occ_w;
  logic [DEPTH:0]      found_c;
  logic [HANDLE_W-1:0] hnd_c [DEPTH+1];

  assign cmd_ready  = !rsp_valid || rsp_ready;
  assign accept     = cmd_valid && cmd_ready;
  assign full       = occ_w[DEPTH-1];
  assign empty      = !occ_w[0];
  assign found      = found_c[DEPTH];
  assign found_c[0] = 1'b0;
  assign hnd_c[0]   = '0;

  always_comb begin
    ctl.op     = OP_NONE;
    ctl.handle = cmd_data.item_handle;
    if (accept) begin
      case (cmd_data.command)
        CMD_PUSH_TAIL: if (!full) ctl.op = OP_PUSH_TAIL;
        CMD_PUSH_HEAD: if (!full) ctl.op = OP_PUSH_HEAD;
        CMD_POP_HEAD:  if (!empty) ctl.op = OP_POP;
        CMD_DELETE:    ctl.op = OP_DELETE;
        default:       ctl.op = OP_NONE;
      endcase
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [HANDLE_W-1:0] left_data;
    logic                left_occ;
    logic [HANDLE_W-1:0] right_data;
    logic                right_occ;

    if (i == 0) begin : g_first
      assign left_data = cmd_data.item_handle;
      assign left_occ  = 1'b1;
    end else begin : g_inner_left
      assign left_data = data_w[i-1];
      assign left_occ  = occ_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_data = '0;
      assign right_occ  = 1'b0;
    end else begin : g_inner_right
      assign right_data = data_w[i+1];
      assign right_occ  = occ_w[i+1];
    end

    dqdel_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .left_data  (left_data),
      .left_occ   (left_occ),
      .right_data (right_data),
      .right_occ  (right_occ),
      .found_in   (found_c[i]),
      .handle_in  (hnd_c[i]),
      .data       (data_w[i]),
      .occ        (occ_w[i]),
      .found_out  (found_c[i+1]),
      .handle_out (hnd_c[i+1])
    );
  end

  always_comb begin
    count_next          = count;
    rsp_next.out_handle = '0;
    rsp_next.status     = ST_OK;
    case (cmd_data.command)
      CMD_PUSH_TAIL, CMD_PUSH_HEAD: begin
        if (full) begin
          rsp_next.status = ST_FULL;
        end else begin
          count_next = count + CNT_W'(1);
        end
      end
      CMD_POP_HEAD: begin
        if (empty) begin
          rsp_next.status = ST_EMPTY;
        end else begin
          rsp_next.out_handle = data_w[0];
          count_next          = count - CNT_W'(1);
        end
      end
      CMD_DELETE: begin
        if (empty) begin
          rsp_next.status = ST_EMPTY;
        end else if (found) begin
          rsp_next.out_handle = hnd_c[DEPTH];
          count_next          = count - CNT_W'(1);
        end else begin
          rsp_next.status = ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
    rsp_next.length = LEN_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_data <= rsp_next;
    end
  end

endmodule

`default_nettype wire

### rtl/core/dqdel_checker.sv
// ----------------------------------------------------------------------------
// Deque port checker
// Watches the ports of the handle deque and flags protocol breaches and
// illegal responses.
// ----------------------------------------------------------------------------
`default_nettype none
`include "deque_with_delete_by_handle_assert.svh"

module dqdel_checker #(
  parameter int DEPTH = 16
) (
  input logic            clk,
  input logic            rst,
  input logic            cmd_valid,
  input logic            cmd_ready,
  input dqdel_pkg::cmd_t cmd_data,
  input logic            rsp_valid,
  input logic            rsp_ready,
  input dqdel_pkg::rsp_t rsp_data
);
  import dqdel_pkg::*;

  `DQDEL_ASSERT_NEXT(a_cmd_hold, cmd_valid && !cmd_ready,
                     cmd_valid && $stable(cmd_data),
                     "Waiting command changed.")
  `DQDEL_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
                     rsp_valid && $stable(rsp_data),
                     "Stalled response changed.")
  `DQDEL_ASSERT_NEXT(a_one_cycle, cmd_valid && cmd_ready, rsp_valid,
                     "No response one cycle after a command transaction.")
  `DQDEL_ASSERT_SAME(a_len_bound, rsp_valid,
                     DEPTH > 31 || 32'(rsp_data.length) <= DEPTH,
                     "Reported length exceeds the depth.")
  `DQDEL_ASSERT_SAME(a_fail_zero, rsp_valid && rsp_data.status != ST_OK,
                     rsp_data.out_handle == '0 &&
                     (rsp_data.status != ST_EMPTY || rsp_data.length == '0),
                     "Failed command returned a handle or an empty queue had entries.")

endmodule

bind deque_with_delete_by_handle dqdel_checker #(.DEPTH(DEPTH)) u_dqdel_checker (.*);

`default_nettype wire
